### rtl/vps_pkg.sv
// vps_pkg: shared types, codes and defaults of the vibration pattern sequencer
// used by vps_ctrl, vps_dp, the top level and the checker; no dependencies

package vps_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int OP_DEPTH_DEF     = 64;

  localparam int REQ_W     = 2;
  localparam int ELAPSED_W = 10;
  localparam int CHAN_W    = 2;
  localparam int IDX_W     = 6;
  localparam int KIND_W    = 2;
  localparam int VAL_W     = 16;
  localparam int OP_W      = KIND_W + VAL_W;
  localparam int CMD_W     = 2;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START = 2'd2;

  localparam logic [KIND_W-1:0] OP_RUMBLE = 2'd0;
  localparam logic [KIND_W-1:0] OP_WAIT   = 2'd1;
  localparam logic [KIND_W-1:0] OP_END    = 2'd2;
  localparam logic [KIND_W-1:0] OP_NOP    = 2'd3;

  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic tick;
    logic wr_op;
    logic start;
    logic rd;
    logic exec;
    logic last;
  } ctl_cmd_t;

  typedef struct packed {
    logic enable;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/vibration_pattern_sequencer_top.sv
// vibration_pattern_sequencer_top: four-channel vibration pattern player
// depends on vps_pkg, vps_ctrl and vps_dp
//
//   channel  signals                       direction  word
//   in       in_valid / in_stall           input      one request
//   out      out_valid / out_stall         output     one channel command
//   cfg      cfg_write / cfg_data          input      sequencer_enable
//
// a write or start request, or a tick while disabled, leaves the input free for the next request
// an enabled tick visits the channels in turn, each with an op memory read and then an
// execute; the execute waits while the output register is stalled
// input is taken again as soon as the last word of a tick is in the output register
// rst is synchronous and clears the enable and channel state; op memory is not cleared

module vibration_pattern_sequencer_top #(
  parameter int NUM_CHANNELS = vps_pkg::NUM_CHANNELS_DEF,
  parameter int OP_DEPTH     = vps_pkg::OP_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [vps_pkg::REQ_W-1:0]         req_type,
  input  logic [vps_pkg::ELAPSED_W-1:0]     elapsed_ms,
  input  logic [vps_pkg::CHAN_W-1:0]        channel,
  input  logic [vps_pkg::IDX_W-1:0]         op_index,
  input  logic [vps_pkg::KIND_W-1:0]        op_kind,
  input  logic [vps_pkg::VAL_W-1:0]         op_value,
  input  logic [vps_pkg::IDX_W-1:0]         start_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vps_pkg::CHAN_W-1:0]        out_channel,
  output logic [vps_pkg::CMD_W-1:0]         motor_cmd,
  output logic [vps_pkg::VAL_W-1:0]         duration_ms,
  output logic                              finished,
  output logic                              last
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  vps_pkg::ctl_cmd_t   cmd;
  vps_pkg::dp_status_t status;
  logic [CW-1:0]       chan_sel;

  vps_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .chan_sel (chan_sel)
  );

  vps_dp #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .OP_DEPTH    (OP_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .elapsed_ms  (elapsed_ms),
    .channel     (channel),
    .op_index    (op_index),
    .op_kind     (op_kind),
    .op_value    (op_value),
    .start_index (start_index),
    .cmd         (cmd),
    .chan_sel    (chan_sel),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .motor_cmd   (motor_cmd),
    .duration_ms (duration_ms),
    .finished    (finished),
    .last        (last)
  );

endmodule

### rtl/vps_ctrl.sv
// vps_ctrl: request decode and per-channel sequencing state machine
// depends on vps_pkg; drives the command struct of vps_dp

module vps_ctrl #(
  parameter int NUM_CHANNELS = vps_pkg::NUM_CHANNELS_DEF,
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [vps_pkg::REQ_W-1:0]      req_type,
  output logic                           in_stall,
  input  vps_pkg::dp_status_t            status,
  output vps_pkg::ctl_cmd_t              cmd,
  output logic [CW-1:0]                  chan_sel
);

  vps_pkg::state_t state, state_next;
  logic [CW-1:0]   chan, chan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vps_pkg::ST_IDLE;
      chan  <= '0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    chan_next  = chan;
    in_stall   = (state != vps_pkg::ST_IDLE);
    case (state)
      vps_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (req_type)
            vps_pkg::REQ_TICK: begin
              if (status.enable) begin
                cmd.tick   = 1'b1;
                chan_next  = '0;
                state_next = vps_pkg::ST_READ;
              end
            end
            vps_pkg::REQ_WRITE: cmd.wr_op = 1'b1;
            vps_pkg::REQ_START: cmd.start = 1'b1;
            default: ;
          endcase
        end
      end
      vps_pkg::ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = vps_pkg::ST_EXEC;
      end
      vps_pkg::ST_EXEC: begin
        if (status.out_free) begin
          cmd.exec = 1'b1;
          cmd.last = (chan == CW'(NUM_CHANNELS - 1));
          if (cmd.last) begin
            state_next = vps_pkg::ST_IDLE;
          end else begin
            chan_next  = chan + 1'b1;
            state_next = vps_pkg::ST_READ;
          end
        end
      end
      default: state_next = vps_pkg::ST_IDLE;
    endcase
  end

  assign chan_sel = chan;

endmodule

### rtl/vps_dp.sv
// vps_dp: channel state, op memory, enable register and output word register
// depends on vps_pkg; steered by vps_ctrl through the command struct

module vps_dp #(
  parameter int NUM_CHANNELS = vps_pkg::NUM_CHANNELS_DEF,
  parameter int OP_DEPTH     = vps_pkg::OP_DEPTH_DEF,
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int AW = $clog2(OP_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_data,
  input  logic [vps_pkg::ELAPSED_W-1:0]     elapsed_ms,
  input  logic [vps_pkg::CHAN_W-1:0]        channel,
  input  logic [vps_pkg::IDX_W-1:0]         op_index,
  input  logic [vps_pkg::KIND_W-1:0]        op_kind,
  input  logic [vps_pkg::VAL_W-1:0]         op_value,
  input  logic [vps_pkg::IDX_W-1:0]         start_index,
  input  vps_pkg::ctl_cmd_t                 cmd,
  input  logic [CW-1:0]                     chan_sel,
  output vps_pkg::dp_status_t               status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vps_pkg::CHAN_W-1:0]        out_channel,
  output logic [vps_pkg::CMD_W-1:0]         motor_cmd,
  output logic [vps_pkg::VAL_W-1:0]         duration_ms,
  output logic                              finished,
  output logic                              last
);

  logic                            enable;
  logic [NUM_CHANNELS-1:0]         active;
  logic [NUM_CHANNELS-1:0]         waiting;
  logic [vps_pkg::VAL_W-1:0]       wait_ms [NUM_CHANNELS];
  logic [AW-1:0]                   step    [NUM_CHANNELS];
  logic [vps_pkg::ELAPSED_W-1:0]   elapsed_q;
  logic                            go_q;
  logic [vps_pkg::OP_W-1:0]        op_mem  [OP_DEPTH];
  logic [vps_pkg::OP_W-1:0]        op_q;

  logic [AW-1:0]                   cur_step, adv_step, rd_step, ex_adv, start_step;
  logic [vps_pkg::VAL_W-1:0]       cur_wait;
  logic                            expired, rd_go;
  logic [vps_pkg::IDX_W-1:0]       start_red;
  logic                            wr_ok, start_ok;
  logic [CW-1:0]                   start_sel;
  logic [vps_pkg::KIND_W-1:0]      ex_kind;
  logic [vps_pkg::VAL_W-1:0]       ex_val;
  logic [vps_pkg::CMD_W-1:0]       ex_cmd;
  logic [vps_pkg::VAL_W-1:0]       ex_dur;
  logic                            ex_fin, ex_arm, ex_skip, ex_end;

  // channel read and wait countdown
  always_comb begin
    cur_step = step[chan_sel];
    cur_wait = wait_ms[chan_sel];
    expired  = (cur_wait <= vps_pkg::VAL_W'(elapsed_q));
    adv_step = (cur_step == AW'(OP_DEPTH - 1)) ? '0 : cur_step + 1'b1;
    rd_step  = (waiting[chan_sel] && expired) ? adv_step : cur_step;
    rd_go    = active[chan_sel] && (!waiting[chan_sel] || expired);
    ex_adv   = adv_step;
  end

  // start index wrap and request range checks
  always_comb begin
    start_red = start_index;
    for (int i = 0; i < 8; i++) begin
      if (int'(start_red) >= OP_DEPTH) begin
        start_red = start_red - vps_pkg::IDX_W'(OP_DEPTH);
      end
    end
    start_step = AW'(start_red);
    wr_ok      = (int'(op_index) < OP_DEPTH);
    start_ok   = (int'(channel) < NUM_CHANNELS);
    start_sel  = CW'(channel);
  end

  // step execution
  always_comb begin
    ex_kind = op_q[vps_pkg::OP_W-1:vps_pkg::VAL_W];
    ex_val  = op_q[vps_pkg::VAL_W-1:0];
    ex_cmd  = vps_pkg::CMD_NONE;
    ex_dur  = '0;
    ex_fin  = 1'b0;
    ex_arm  = 1'b0;
    ex_skip = 1'b0;
    ex_end  = 1'b0;
    if (go_q) begin
      case (ex_kind)
        vps_pkg::OP_RUMBLE: begin
          if (ex_val != '0) begin
            ex_cmd = vps_pkg::CMD_START;
            ex_dur = ex_val;
            ex_arm = 1'b1;
          end else begin
            ex_skip = 1'b1;
          end
        end
        vps_pkg::OP_WAIT: begin
          ex_cmd = vps_pkg::CMD_STOP;
          if (ex_val != '0) begin
            ex_arm = 1'b1;
          end else begin
            ex_skip = 1'b1;
          end
        end
        vps_pkg::OP_END: begin
          ex_cmd = vps_pkg::CMD_STOP;
          ex_fin = 1'b1;
          ex_end = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      active    <= '0;
      waiting   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wait_ms[i] <= '0;
        step[i]    <= '0;
      end
    end else begin
      if (cfg_write) begin
        enable <= cfg_data;
      end
      if (cmd.start && start_ok) begin
        active[start_sel]  <= 1'b1;
        waiting[start_sel] <= 1'b0;
        wait_ms[start_sel] <= '0;
        step[start_sel]    <= start_step;
      end
      if (cmd.rd && active[chan_sel] && waiting[chan_sel]) begin
        if (expired) begin
          wait_ms[chan_sel] <= '0;
          waiting[chan_sel] <= 1'b0;
          step[chan_sel]    <= adv_step;
        end else begin
          wait_ms[chan_sel] <= cur_wait - vps_pkg::VAL_W'(elapsed_q);
        end
      end
      if (cmd.exec) begin
        if (ex_arm) begin
          wait_ms[chan_sel] <= ex_val;
          waiting[chan_sel] <= 1'b1;
        end
        if (ex_skip) begin
          step[chan_sel] <= ex_adv;
        end
        if (ex_end) begin
          active[chan_sel] <= 1'b0;
        end
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // op memory and payload registers
  always_ff @(posedge clk) begin
    if (cmd.wr_op && wr_ok) begin
      op_mem[AW'(op_index)] <= {op_kind, op_value};
    end
    if (cmd.rd) begin
      op_q <= op_mem[rd_step];
      go_q <= rd_go;
    end
    if (cmd.tick) begin
      elapsed_q <= elapsed_ms;
    end
    if (cmd.exec) begin
      out_channel <= vps_pkg::CHAN_W'(chan_sel);
      motor_cmd   <= ex_cmd;
      duration_ms <= ex_dur;
      finished    <= ex_fin;
      last        <= cmd.last;
    end
  end

  assign status.enable   = enable;
  assign status.out_free = !out_valid || !out_stall;

endmodule

### rtl/vps_checker.sv
// vps_checker: port-level assertions for the vibration pattern sequencer
// depends on vps_pkg; bound to vibration_pattern_sequencer_top

module vps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [vps_pkg::CHAN_W-1:0]        out_channel,
  input logic [vps_pkg::CMD_W-1:0]         motor_cmd,
  input logic [vps_pkg::VAL_W-1:0]         duration_ms,
  input logic                              finished,
  input logic                              last
);

  // a tick holds off new requests until its last word is in the output register
  a_mid_tick_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("request accepted in the middle of a tick");

  a_finish_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> motor_cmd == vps_pkg::CMD_STOP)
    else $error("finished word without stop command");

  a_duration_start_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_cmd != vps_pkg::CMD_START |-> duration_ms == '0)
    else $error("duration on a word that is not a start command");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_channel) &&
      $stable(motor_cmd) && $stable(duration_ms) && $stable(finished) && $stable(last))
    else $error("stalled output word changed");

endmodule

bind vibration_pattern_sequencer_top vps_checker u_vps_checker (.*);

### bench/vps_cmd_checker.sv
`timescale 1ns / 100ps
// vps_cmd_checker: watches the request, config and command channels of the
// vibration pattern sequencer, predicts every command word and compares; uses vps_pkg

module vps_cmd_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic                            cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [vps_pkg::REQ_W-1:0]       req_type,
  input  logic [vps_pkg::ELAPSED_W-1:0]   elapsed_ms,
  input  logic [vps_pkg::CHAN_W-1:0]      channel,
  input  logic [vps_pkg::IDX_W-1:0]       op_index,
  input  logic [vps_pkg::KIND_W-1:0]      op_kind,
  input  logic [vps_pkg::VAL_W-1:0]       op_value,
  input  logic [vps_pkg::IDX_W-1:0]       start_index,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [vps_pkg::CHAN_W-1:0]      out_channel,
  input  logic [vps_pkg::CMD_W-1:0]       motor_cmd,
  input  logic [vps_pkg::VAL_W-1:0]       duration_ms,
  input  logic                            finished,
  input  logic                            last,
  output int                              fail_count,
  output int                              words_due
);

  localparam int NCH       = vps_pkg::NUM_CHANNELS_DEF;
  localparam int DEPTH     = vps_pkg::OP_DEPTH_DEF;
  localparam int CHAN_W    = vps_pkg::CHAN_W;
  localparam int CMD_W     = vps_pkg::CMD_W;
  localparam int VAL_W     = vps_pkg::VAL_W;
  localparam int IDX_W     = vps_pkg::IDX_W;
  localparam int KIND_W    = vps_pkg::KIND_W;
  localparam int OP_W      = vps_pkg::OP_W;
  localparam int ELAPSED_W = vps_pkg::ELAPSED_W;

  typedef struct packed {
    logic [CHAN_W-1:0] ch;
    logic [CMD_W-1:0]  cmd;
    logic [VAL_W-1:0]  dur;
    logic              fin;
    logic              lst;
  } cmd_word_t;

  logic              seq_on;
  logic              chan_on   [NCH];
  logic [IDX_W-1:0]  chan_pc   [NCH];
  logic              chan_hold [NCH];
  logic [17:0]       chan_left [NCH];
  logic [OP_W-1:0]   op_mem    [DEPTH];
  cmd_word_t         cmd_due_q [$];
  int                fails = 0;
  cmd_word_t         got;
  cmd_word_t         want;

  task automatic advance_channels(input logic [ELAPSED_W-1:0] el);
    int               c;
    logic             go;
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0] val;
    cmd_word_t        w;
    for (c = 0; c < NCH; c++) begin
      w     = '0;
      w.ch  = c[CHAN_W-1:0];
      w.cmd = vps_pkg::CMD_NONE;
      w.lst = (c == NCH - 1);
      if (chan_on[c]) begin
        go = 1'b1;
        if (chan_hold[c]) begin
          if (chan_left[c] > {8'd0, el}) begin
            chan_left[c] = chan_left[c] - {8'd0, el};
            go = 1'b0;
          end else begin
            chan_left[c] = '0;
            chan_pc[c]   = chan_pc[c] + 1'b1;
            chan_hold[c] = 1'b0;
          end
        end
        if (go) begin
          kind = op_mem[chan_pc[c]][OP_W-1:VAL_W];
          val  = op_mem[chan_pc[c]][VAL_W-1:0];
          case (kind)
            vps_pkg::OP_RUMBLE: begin
              if (val != 0) begin
                chan_left[c] = {2'd0, val};
                chan_hold[c] = 1'b1;
                w.cmd = vps_pkg::CMD_START;
                w.dur = val;
              end else begin
                chan_pc[c] = chan_pc[c] + 1'b1;
              end
            end
            vps_pkg::OP_WAIT: begin
              w.cmd = vps_pkg::CMD_STOP;
              if (val != 0) begin
                chan_left[c] = {2'd0, val};
                chan_hold[c] = 1'b1;
              end else begin
                chan_pc[c] = chan_pc[c] + 1'b1;
              end
            end
            vps_pkg::OP_END: begin
              w.cmd = vps_pkg::CMD_STOP;
              w.fin = 1'b1;
              chan_on[c] = 1'b0;
            end
            default: ;
          endcase
        end
      end
      cmd_due_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seq_on = 1'b0;
      for (int c = 0; c < NCH; c++) begin
        chan_on[c]   = 1'b0;
        chan_pc[c]   = '0;
        chan_hold[c] = 1'b0;
        chan_left[c] = '0;
      end
      cmd_due_q.delete();
    end else begin
      if (cfg_write)
        seq_on = cfg_data;
      if (in_valid && !in_stall) begin
        case (req_type)
          vps_pkg::REQ_WRITE: op_mem[op_index] = {op_kind, op_value};
          vps_pkg::REQ_START: begin
            chan_on[channel]   = 1'b1;
            chan_pc[channel]   = start_index;
            chan_hold[channel] = 1'b0;
            chan_left[channel] = '0;
          end
          vps_pkg::REQ_TICK: if (seq_on) advance_channels(elapsed_ms);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{ch: out_channel, cmd: motor_cmd, dur: duration_ms, fin: finished, lst: last};
        if (cmd_due_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $realtime, got);
          fails++;
        end else begin
          want = cmd_due_q.pop_front();
          if (got.ch !== want.ch) begin
            $display("%0t: out_channel expected %0d actual %0d", $realtime, want.ch, got.ch);
            fails++;
          end
          if (got.cmd !== want.cmd) begin
            $display("%0t: motor_cmd expected %0d actual %0d", $realtime, want.cmd, got.cmd);
            fails++;
          end
          if (got.dur !== want.dur) begin
            $display("%0t: duration_ms expected %0d actual %0d", $realtime, want.dur, got.dur);
            fails++;
          end
          if (got.fin !== want.fin) begin
            $display("%0t: finished expected %0d actual %0d", $realtime, want.fin, got.fin);
            fails++;
          end
          if (got.lst !== want.lst) begin
            $display("%0t: last expected %0d actual %0d", $realtime, want.lst, got.lst);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    words_due  <= cmd_due_q.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: request stimulus, random output stalls and the verdict for
// vibration_pattern_sequencer_top; uses vps_pkg and vps_cmd_checker

module tb_top;

  localparam int REQ_W     = vps_pkg::REQ_W;
  localparam int ELAPSED_W = vps_pkg::ELAPSED_W;
  localparam int CHAN_W    = vps_pkg::CHAN_W;
  localparam int IDX_W     = vps_pkg::IDX_W;
  localparam int KIND_W    = vps_pkg::KIND_W;
  localparam int VAL_W     = vps_pkg::VAL_W;
  localparam int CMD_W     = vps_pkg::CMD_W;
  localparam int DEPTH     = vps_pkg::OP_DEPTH_DEF;

  localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;
  localparam int LIMIT  = 400000;
  localparam int SETTLE = 12;
  localparam int ITEMS  = 165;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type = '0;
  logic [ELAPSED_W-1:0] elapsed_ms = '0;
  logic [CHAN_W-1:0]    channel = '0;
  logic [IDX_W-1:0]     op_index = '0;
  logic [KIND_W-1:0]    op_kind = '0;
  logic [VAL_W-1:0]     op_value = '0;
  logic [IDX_W-1:0]     start_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAN_W-1:0]    out_channel;
  logic [CMD_W-1:0]     motor_cmd;
  logic [VAL_W-1:0]     duration_ms;
  logic                 finished;
  logic                 last;

  int   fail_count;
  int   words_due;
  int   cycle_count = 0;
  int   word_count = 0;
  int   stall_run = 0;
  int   stall_pick;
  logic calm = 1'b0;
  logic op_set [DEPTH];

  always #10 clk = ~clk;

  vibration_pattern_sequencer_top DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .elapsed_ms(elapsed_ms), .channel(channel), .op_index(op_index),
    .op_kind(op_kind), .op_value(op_value), .start_index(start_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
    .motor_cmd(motor_cmd), .duration_ms(duration_ms), .finished(finished),
    .last(last)
  );

  vps_cmd_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .elapsed_ms(elapsed_ms), .channel(channel), .op_index(op_index),
    .op_kind(op_kind), .op_value(op_value), .start_index(start_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
    .motor_cmd(motor_cmd), .duration_ms(duration_ms), .finished(finished),
    .last(last), .fail_count(fail_count), .words_due(words_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver back-pressure: mostly open, short and occasional long stalls
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run = stall_run - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 12) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else if (stall_pick < 15) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(10, 40);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_dur();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return '0;
    if (r < 85)
      return VAL_W'($urandom_range(1, 200));
    if (r < 95)
      return VAL_W'($urandom_range(201, 2000));
    return VAL_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return '0;
    if (r < 80)
      return ELAPSED_W'($urandom_range(1, 250));
    if (r < 92)
      return ELAPSED_W'($urandom_range(251, 1022));
    return 10'h3ff;
  endfunction

  task automatic send_word(input logic [REQ_W-1:0] rt, input logic [ELAPSED_W-1:0] el,
                           input logic [CHAN_W-1:0] ch, input logic [IDX_W-1:0] idx,
                           input logic [KIND_W-1:0] kd, input logic [VAL_W-1:0] val,
                           input logic [IDX_W-1:0] si);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rt;
    elapsed_ms  <= el;
    channel     <= ch;
    op_index    <= idx;
    op_kind     <= kd;
    op_value    <= val;
    start_index <= si;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (rt == vps_pkg::REQ_WRITE)
      op_set[idx] = 1'b1;
    word_count++;
  endtask

  // sender holds off until every command word has come out and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_enable(input logic on);
    settle();
    cfg_data  <= on;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // program written back to front so every advancing step lands on a written entry
  task automatic play_program();
    int               len;
    int               k;
    int               n;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] at;
    logic [KIND_W-1:0] kd;
    len  = $urandom_range(1, 6);
    base = IDX_W'($urandom);
    at   = base + IDX_W'(len - 1);
    kd   = ($urandom_range(0, 7) == 0) ? vps_pkg::OP_NOP : vps_pkg::OP_END;
    send_word(vps_pkg::REQ_WRITE, ELAPSED_W'($urandom), CHAN_W'($urandom), at, kd,
              VAL_W'($urandom), IDX_W'($urandom));
    for (k = len - 2; k >= 0; k--) begin
      at = base + IDX_W'(k);
      kd = $urandom_range(0, 1) ? vps_pkg::OP_RUMBLE : vps_pkg::OP_WAIT;
      send_word(vps_pkg::REQ_WRITE, ELAPSED_W'($urandom), CHAN_W'($urandom), at, kd,
                pick_dur(), IDX_W'($urandom));
    end
    send_word(vps_pkg::REQ_START, ELAPSED_W'($urandom), CHAN_W'($urandom_range(0, 3)),
              IDX_W'($urandom), KIND_W'($urandom), VAL_W'($urandom), base);
    n = $urandom_range(2, 7);
    for (k = 0; k < n; k++)
      send_word(vps_pkg::REQ_TICK, pick_elapsed(), CHAN_W'($urandom), IDX_W'($urandom),
                KIND_W'($urandom), VAL_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic noise_word();
    logic [REQ_W-1:0]  rt;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  nxt;
    logic [KIND_W-1:0] kd;
    logic [IDX_W-1:0]  si;
    rt  = REQ_W'($urandom_range(0, 3));
    idx = IDX_W'($urandom);
    kd  = KIND_W'($urandom);
    si  = IDX_W'($urandom);
    nxt = idx + 1'b1;
    if (rt == vps_pkg::REQ_WRITE && (kd == vps_pkg::OP_RUMBLE || kd == vps_pkg::OP_WAIT) &&
        !op_set[nxt])
      kd = $urandom_range(0, 1) ? vps_pkg::OP_END : vps_pkg::OP_NOP;
    if (rt == vps_pkg::REQ_START)
      while (!op_set[si]) si = IDX_W'($urandom);
    send_word(rt, ELAPSED_W'($urandom), CHAN_W'($urandom), idx, kd, VAL_W'($urandom), si);
  endtask

  initial begin
    int ph;
    int phase_end;
    for (int i = 0; i < DEPTH; i++)
      op_set[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_enable(1'b0);
    send_word(vps_pkg::REQ_TICK, 10'd5, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);
    send_word(REQ_BAD, 10'h3ff, 2'd3, 6'h3f, vps_pkg::OP_NOP, 16'hffff, 6'h3f);
    send_word(vps_pkg::REQ_WRITE, 10'd0, 2'd0, 6'd1, vps_pkg::OP_END, 16'hffff, 6'd0);
    send_word(vps_pkg::REQ_WRITE, 10'd0, 2'd0, 6'd0, vps_pkg::OP_WAIT, 16'd0, 6'd0);
    send_word(vps_pkg::REQ_WRITE, 10'd0, 2'd0, 6'd63, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);
    send_word(vps_pkg::REQ_WRITE, 10'd0, 2'd0, 6'd62, vps_pkg::OP_WAIT, 16'd3, 6'd0);
    send_word(vps_pkg::REQ_WRITE, 10'd0, 2'd0, 6'd61, vps_pkg::OP_RUMBLE, 16'd1, 6'd0);
    send_word(vps_pkg::REQ_WRITE, 10'd0, 2'd0, 6'd60, vps_pkg::OP_RUMBLE, 16'hffff, 6'd0);
    send_word(vps_pkg::REQ_WRITE, 10'd0, 2'd0, 6'd10, vps_pkg::OP_NOP, 16'h5a5a, 6'd0);
    send_word(vps_pkg::REQ_START, 10'd0, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd61);
    send_word(vps_pkg::REQ_START, 10'd0, 2'd1, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd60);
    send_word(vps_pkg::REQ_START, 10'd0, 2'd2, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd10);
    send_word(vps_pkg::REQ_START, 10'd0, 2'd3, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd63);
    set_enable(1'b1);
    send_word(vps_pkg::REQ_TICK, 10'd0, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);
    send_word(vps_pkg::REQ_TICK, 10'd1, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);
    send_word(vps_pkg::REQ_TICK, 10'h3ff, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);
    send_word(vps_pkg::REQ_TICK, 10'd2, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);
    send_word(vps_pkg::REQ_TICK, 10'd0, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);
    send_word(vps_pkg::REQ_START, 10'd0, 2'd1, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd1);
    send_word(vps_pkg::REQ_TICK, 10'd0, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);
    send_word(vps_pkg::REQ_TICK, 10'h3ff, 2'd0, 6'd0, vps_pkg::OP_RUMBLE, 16'd0, 6'd0);

    ph = 0;
    phase_end = word_count;
    while (word_count < ITEMS) begin
      if (word_count >= phase_end) begin
        calm <= ($urandom_range(0, 3) == 0);
        if (ph == 2)
          set_enable(1'b0);
        else if (ph == 0 || ph == 3)
          set_enable(1'b1);
        else
          set_enable($urandom_range(0, 4) != 0);
        ph++;
        phase_end = word_count + 20;
      end
      if ($urandom_range(0, 99) < 60)
        play_program();
      else
        noise_word();
      if ($urandom_range(0, 29) == 0)
        settle();
    end

    settle();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
